// ===== design/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared field widths, command codes, search operators and status codes for
// the record ring time offset search block.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned OPER_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned COUNT_W  = 9;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [OPER_W-1:0] OP_ALL      = 3'd1;
  localparam logic [OPER_W-1:0] OP_AT_MOST  = 3'd2;
  localparam logic [OPER_W-1:0] OP_AT_LEAST = 3'd3;
  localparam logic [OPER_W-1:0] OP_RANGE    = 3'd4;
  localparam logic [OPER_W-1:0] OP_FIRST    = 3'd5;
  localparam logic [OPER_W-1:0] OP_LAST     = 3'd6;

  localparam logic [STATUS_W-1:0] ST_SUCCESS   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_RECORD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAIL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

endpackage

// ===== design/record_ring_time_offset_search.sv =====
// An add, an empty-store search, all, first, last, a bad operator or an inverted
// range goes from the accepted input beat to the emit state, which registers
// out_valid. At most, at least and range read one entry per cycle from the
// oldest, then pass through the finish state to the emit state.
// One item is in flight at a time, and a result held by out_ready stalls the input.
// ----------------------------------------------------------------------------
// record_ring_time_offset_search
// Ring store of record time offsets with add and search commands. The store
// is a single synchronous memory; bounded searches stream it in order and stop
// at the newest entry or once the bounds that the operator needs are located.
// Reset clears the oldest pointer and the count; the offset store is not cleared.
// ----------------------------------------------------------------------------
module record_ring_time_offset_search #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [rrts_pkg::OFFSET_W-1:0]  in_time_offset,
  input  logic [rrts_pkg::OPER_W-1:0]    in_search_operator,
  input  logic [rrts_pkg::OFFSET_W-1:0]  in_operand_low,
  input  logic [rrts_pkg::OFFSET_W-1:0]  in_operand_high,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rrts_pkg::STATUS_W-1:0]  out_status,
  output logic [rrts_pkg::INDEX_W-1:0]   out_first_index,
  output logic [rrts_pkg::INDEX_W-1:0]   out_last_index,
  output logic [rrts_pkg::COUNT_W-1:0]   out_match_count
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_EMIT
  } state_t;

  // Store position of logical position p counted from the oldest entry.
  function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                             input logic [CW-1:0] p);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(p);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  // Offset store
  logic [rrts_pkg::OFFSET_W-1:0] mem [DEPTH];
  logic [rrts_pkg::OFFSET_W-1:0] mem_q;
  logic                          mem_we;
  logic [IW-1:0]                 mem_waddr;
  logic [IW-1:0]                 mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_time_offset;
    end
    mem_q <= mem[mem_raddr];
  end

  state_t                        state_r, state_nxt;
  logic [IW-1:0]                 oldest_r, oldest_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [rrts_pkg::OPER_W-1:0]   op_r, op_nxt;
  logic [rrts_pkg::OFFSET_W-1:0] lo_r, lo_nxt;
  logic [rrts_pkg::OFFSET_W-1:0] hi_r, hi_nxt;
  logic [CW-1:0]                 scan_p_r, scan_p_nxt;
  logic                          chk_v_r, chk_v_nxt;
  logic [CW-1:0]                 chk_p_r, chk_p_nxt;
  logic                          ps_found_r, ps_found_nxt;
  logic [CW-1:0]                 ps_r, ps_nxt;
  logic                          pe_found_r, pe_found_nxt;
  logic [CW-1:0]                 pe_r, pe_nxt;
  logic [rrts_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [IW-1:0]                 res_first_r, res_first_nxt;
  logic [IW-1:0]                 res_last_r, res_last_nxt;
  logic [CW-1:0]                 res_count_r, res_count_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rrts_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [rrts_pkg::INDEX_W-1:0]  out_first_r, out_first_nxt;
  logic [rrts_pkg::INDEX_W-1:0]  out_last_r, out_last_nxt;
  logic [rrts_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic [CW-1:0]                 cnt_m1;
  logic [IW-1:0]                 add_w;
  logic                          need_ge;
  logic                          need_le;
  logic [rrts_pkg::OFFSET_W-1:0] le_bound;
  logic                          ge_hit;
  logic                          le_hit;
  logic                          scan_done;
  logic [CW-1:0]                 ps_e;
  logic [CW-1:0]                 pe_e;
  logic [CW-1:0]                 fin_fp;
  logic [CW-1:0]                 fin_lp;
  logic                          fin_none;
  logic                          out_free;
  logic [IW+rrts_pkg::INDEX_W-1:0] first_ext;
  logic [IW+rrts_pkg::INDEX_W-1:0] last_ext;
  logic [CW+rrts_pkg::COUNT_W-1:0] count_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign cnt_m1    = count_r - CW'(1);
  assign add_w     = (count_r < CW'(DEPTH)) ? ring_pos(oldest_r, count_r) : oldest_r;
  assign mem_waddr = add_w;
  assign mem_raddr = ring_pos(oldest_r, scan_p_r);

  assign need_ge  = (op_r == rrts_pkg::OP_AT_LEAST) || (op_r == rrts_pkg::OP_RANGE);
  assign need_le  = (op_r == rrts_pkg::OP_AT_MOST) || (op_r == rrts_pkg::OP_RANGE);
  assign le_bound = (op_r == rrts_pkg::OP_AT_MOST) ? lo_r : hi_r;
  assign ge_hit   = chk_v_r && !ps_found_r && (mem_q >= lo_r);
  assign le_hit   = chk_v_r && !pe_found_r && (mem_q > le_bound);
  // The scan ends on the last stored entry or once every needed bound is seen.
  assign scan_done = chk_v_r &&
                     ((chk_p_r == cnt_m1) ||
                      ((!need_ge || ps_found_r || ge_hit) &&
                       (!need_le || pe_found_r || le_hit)));

  assign ps_e = ps_found_r ? ps_r : count_r;
  assign pe_e = pe_found_r ? pe_r : count_r;

  always_comb begin
    fin_fp   = '0;
    fin_lp   = cnt_m1;
    fin_none = 1'b0;
    case (op_r)
      rrts_pkg::OP_AT_LEAST: begin
        fin_none = !ps_found_r;
        fin_fp   = ps_e;
      end
      rrts_pkg::OP_AT_MOST: begin
        fin_none = (pe_e == '0);
        fin_lp   = pe_e - CW'(1);
      end
      rrts_pkg::OP_RANGE: begin
        fin_none = !ps_found_r || (pe_e == '0) || (pe_e <= ps_e);
        fin_fp   = ps_e;
        fin_lp   = pe_e - CW'(1);
      end
      default: begin
        fin_none = 1'b1;
      end
    endcase
  end

  assign first_ext = {{rrts_pkg::INDEX_W{1'b0}}, res_first_r};
  assign last_ext  = {{rrts_pkg::INDEX_W{1'b0}}, res_last_r};
  assign count_ext = {{rrts_pkg::COUNT_W{1'b0}}, res_count_r};

  always_comb begin
    state_nxt      = state_r;
    oldest_nxt     = oldest_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    scan_p_nxt     = scan_p_r;
    chk_v_nxt      = 1'b0;
    chk_p_nxt      = chk_p_r;
    ps_found_nxt   = ps_found_r;
    ps_nxt         = ps_r;
    pe_found_nxt   = pe_found_r;
    pe_nxt         = pe_r;
    res_status_nxt = res_status_r;
    res_first_nxt  = res_first_r;
    res_last_nxt   = res_last_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_search_operator;
          lo_nxt         = in_operand_low;
          hi_nxt         = in_operand_high;
          res_status_nxt = rrts_pkg::ST_NO_RECORD;
          res_first_nxt  = '0;
          res_last_nxt   = '0;
          res_count_nxt  = '0;
          state_nxt      = S_EMIT;
          if (in_command == rrts_pkg::CMD_ADD) begin
            mem_we         = 1'b1;
            res_status_nxt = rrts_pkg::ST_SUCCESS;
            res_first_nxt  = add_w;
            res_last_nxt   = add_w;
            if (count_r < CW'(DEPTH)) begin
              count_nxt     = count_r + CW'(1);
              res_count_nxt = count_r + CW'(1);
            end else begin
              oldest_nxt    = ring_pos(oldest_r, CW'(1));
              res_count_nxt = count_r;
            end
          end else if (count_r != '0) begin
            case (in_search_operator)
              rrts_pkg::OP_ALL: begin
                res_status_nxt = rrts_pkg::ST_SUCCESS;
                res_first_nxt  = oldest_r;
                res_last_nxt   = ring_pos(oldest_r, cnt_m1);
                res_count_nxt  = count_r;
              end
              rrts_pkg::OP_FIRST: begin
                res_status_nxt = rrts_pkg::ST_SUCCESS;
                res_first_nxt  = oldest_r;
                res_last_nxt   = oldest_r;
                res_count_nxt  = CW'(1);
              end
              rrts_pkg::OP_LAST: begin
                res_status_nxt = rrts_pkg::ST_SUCCESS;
                res_first_nxt  = ring_pos(oldest_r, cnt_m1);
                res_last_nxt   = ring_pos(oldest_r, cnt_m1);
                res_count_nxt  = CW'(1);
              end
              rrts_pkg::OP_AT_MOST, rrts_pkg::OP_AT_LEAST, rrts_pkg::OP_RANGE: begin
                if ((in_search_operator == rrts_pkg::OP_RANGE) &&
                    (in_operand_low > in_operand_high)) begin
                  res_status_nxt = rrts_pkg::ST_INVALID;
                end else begin
                  state_nxt    = S_SCAN;
                  scan_p_nxt   = '0;
                  ps_found_nxt = 1'b0;
                  pe_found_nxt = 1'b0;
                end
              end
              default: begin
                res_status_nxt = rrts_pkg::ST_FAIL;
              end
            endcase
          end
        end
      end

      S_SCAN: begin
        // Reads are issued one per cycle; each is checked in the cycle after its read.
        if (scan_p_r < count_r) begin
          chk_v_nxt  = 1'b1;
          chk_p_nxt  = scan_p_r;
          scan_p_nxt = scan_p_r + CW'(1);
        end
        if (ge_hit) begin
          ps_found_nxt = 1'b1;
          ps_nxt       = chk_p_r;
        end
        if (le_hit) begin
          pe_found_nxt = 1'b1;
          pe_nxt       = chk_p_r;
        end
        if (scan_done) begin
          chk_v_nxt = 1'b0;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        state_nxt = S_EMIT;
        if (fin_none) begin
          res_status_nxt = rrts_pkg::ST_NO_RECORD;
          res_first_nxt  = '0;
          res_last_nxt   = '0;
          res_count_nxt  = '0;
        end else begin
          res_status_nxt = rrts_pkg::ST_SUCCESS;
          res_first_nxt  = ring_pos(oldest_r, fin_fp);
          res_last_nxt   = ring_pos(oldest_r, fin_lp);
          res_count_nxt  = fin_lp - fin_fp + CW'(1);
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_first_nxt  = first_ext[rrts_pkg::INDEX_W-1:0];
          out_last_nxt   = last_ext[rrts_pkg::INDEX_W-1:0];
          out_count_nxt  = count_ext[rrts_pkg::COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    scan_p_r     <= scan_p_nxt;
    chk_p_r      <= chk_p_nxt;
    ps_found_r   <= ps_found_nxt;
    ps_r         <= ps_nxt;
    pe_found_r   <= pe_found_nxt;
    pe_r         <= pe_nxt;
    res_status_r <= res_status_nxt;
    res_first_r  <= res_first_nxt;
    res_last_r   <= res_last_nxt;
    res_count_r  <= res_count_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_first_index = out_first_r;
  assign out_last_index  = out_last_r;
  assign out_match_count = out_count_r;

endmodule
